### sv/slt_pkg.sv
// Shared types, constants and helpers for the source lexer tokenizer.
// No dependencies; used by every module of the block.
`default_nettype none
package slt_pkg;

  // Source size bound and the derived byte-offset ceiling
  localparam int MAX_SOURCE_BYTES = 65536;
  localparam int OFFSET_CAP_INT   = (MAX_SOURCE_BYTES - 1 < 65535) ?
                                    (MAX_SOURCE_BYTES - 1) : 65535;
  localparam logic [15:0] OFFSET_CAP = 16'(OFFSET_CAP_INT);
  localparam logic [15:0] CNT_MAX    = 16'hFFFF;

  // Result queue sizing
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  // Token kinds
  localparam logic [4:0] KIND_STR = 5'd14;
  localparam logic [4:0] KIND_NUM = 5'd15;
  localparam logic [4:0] KIND_ID  = 5'd16;
  localparam logic [4:0] KIND_ILL = 5'd17;
  localparam logic [4:0] KIND_END = 5'd18;

  // Character codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UZ    = 8'h5A;
  localparam logic [7:0] CH_US    = 8'h5F;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LZ    = 8'h7A;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_STR  = 2'd1,
    MODE_NUM  = 2'd2,
    MODE_ID   = 2'd3
  } scan_mode_t;

  // One result word
  typedef struct packed {
    logic [4:0]  kind;
    logic [15:0] start;
    logic [15:0] len;
    logic [15:0] line;
    logic [15:0] col;
    logic        err;
    logic        last;
  } tok_t;

  // Punctuator lookup: kind code, bit 4 set when the byte is no punctuator
  function automatic logic [4:0] punct_code(input logic [7:0] c);
    logic [4:0] r;
    r = 5'h10;
    case (c)
      8'h28:   r = 5'd0;   // (
      8'h29:   r = 5'd1;   // )
      8'h3B:   r = 5'd2;   // ;
      8'h2C:   r = 5'd3;   // ,
      8'h3D:   r = 5'd4;   // =
      8'h21:   r = 5'd5;   // !
      8'h7B:   r = 5'd6;   // {
      8'h7D:   r = 5'd7;   // }
      8'h2B:   r = 5'd8;   // +
      8'h2D:   r = 5'd9;   // -
      8'h2A:   r = 5'd10;  // *
      8'h2F:   r = 5'd11;  // /
      8'h3C:   r = 5'd12;  // <
      8'h3E:   r = 5'd13;  // >
      default: r = 5'h10;  // no punctuator
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

### sv/slt_scan.sv
// Scanner state and per-byte token decision: up to two result words per byte.
// Depends on slt_pkg.
`default_nettype none
module slt_scan (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        fire,
  input  wire logic [7:0]  cur_byte,
  output slt_pkg::tok_t    res0,
  output slt_pkg::tok_t    res1,
  output logic [1:0]       res_cnt
);

  slt_pkg::scan_mode_t mode, mode_next;
  logic [15:0] byte_offset, byte_offset_next;
  logic [15:0] token_start, token_start_next;
  logic [15:0] token_start_column, token_start_column_next;
  logic [15:0] current_line, current_line_next;
  logic [15:0] current_column, current_column_next;
  logic        error_seen, error_seen_next;

  logic [15:0]   off_inc, col_inc, line_inc, pend_len;
  logic          is_digit, is_word_char, pend_emit, own_emit;
  logic [4:0]    pcode;
  slt_pkg::tok_t pend_tok, own_tok;

  // Saturating increments and classification
  always_comb begin
    off_inc  = (byte_offset >= slt_pkg::OFFSET_CAP) ? slt_pkg::OFFSET_CAP
                                                    : byte_offset + 16'd1;
    col_inc  = (current_column == slt_pkg::CNT_MAX) ? slt_pkg::CNT_MAX
                                                    : current_column + 16'd1;
    line_inc = (current_line == slt_pkg::CNT_MAX) ? slt_pkg::CNT_MAX
                                                  : current_line + 16'd1;
    pend_len = (byte_offset >= token_start) ? byte_offset - token_start : 16'd0;
    is_digit = cur_byte inside {[slt_pkg::CH_0:slt_pkg::CH_9]};
    is_word_char = cur_byte inside {[slt_pkg::CH_LA:slt_pkg::CH_LZ],
                                    [slt_pkg::CH_UA:slt_pkg::CH_UZ], slt_pkg::CH_US};
    pcode    = slt_pkg::punct_code(cur_byte);
  end

  // Pending token built from the open lexeme
  always_comb begin
    pend_tok.kind  = (mode == slt_pkg::MODE_STR) ? slt_pkg::KIND_STR :
                     (mode == slt_pkg::MODE_NUM) ? slt_pkg::KIND_NUM : slt_pkg::KIND_ID;
    pend_tok.start = token_start;
    pend_tok.len   = pend_len;
    pend_tok.line  = current_line;
    pend_tok.col   = token_start_column;
    pend_tok.err   = 1'b0;
    pend_tok.last  = 1'b0;
  end

  // Next state and emitted words
  always_comb begin
    mode_next               = mode;
    byte_offset_next        = byte_offset;
    token_start_next        = token_start;
    token_start_column_next = token_start_column;
    current_line_next       = current_line;
    current_column_next     = current_column;
    error_seen_next         = error_seen;
    pend_emit               = 1'b0;
    own_emit                = 1'b0;
    own_tok.kind            = slt_pkg::KIND_ILL;
    own_tok.start           = byte_offset;
    own_tok.len             = 16'd1;
    own_tok.line            = current_line;
    own_tok.col             = current_column;
    own_tok.err             = 1'b0;
    own_tok.last            = 1'b1;

    if (cur_byte == slt_pkg::CH_NUL) begin
      // end of text: flush, end marker, back to reset values
      pend_emit               = (mode != slt_pkg::MODE_IDLE);
      own_emit                = 1'b1;
      own_tok.kind            = slt_pkg::KIND_END;
      own_tok.len             = 16'd0;
      own_tok.err             = error_seen;
      mode_next               = slt_pkg::MODE_IDLE;
      byte_offset_next        = 16'd0;
      token_start_next        = 16'd0;
      token_start_column_next = 16'd1;
      current_line_next       = 16'd1;
      current_column_next     = 16'd1;
      error_seen_next         = 1'b0;
    end else if (mode == slt_pkg::MODE_STR) begin
      // inside a string only the closing quote matters
      if (cur_byte == slt_pkg::CH_QUOTE) begin
        pend_emit = 1'b1;
        mode_next = slt_pkg::MODE_IDLE;
      end
      byte_offset_next    = off_inc;
      current_column_next = col_inc;
    end else if ((mode == slt_pkg::MODE_NUM && is_digit) ||
                 (mode == slt_pkg::MODE_ID && is_word_char)) begin
      byte_offset_next    = off_inc;
      current_column_next = col_inc;
    end else begin
      // close any open lexeme, then handle this byte on its own
      pend_emit           = (mode != slt_pkg::MODE_IDLE);
      mode_next           = slt_pkg::MODE_IDLE;
      byte_offset_next    = off_inc;
      current_column_next = col_inc;
      if (cur_byte == slt_pkg::CH_LF) begin
        current_line_next   = line_inc;
        current_column_next = 16'd1;
      end else if (cur_byte inside {slt_pkg::CH_SPACE, slt_pkg::CH_TAB,
                                    slt_pkg::CH_CR}) begin
        own_emit = 1'b0;
      end else if (!pcode[4]) begin
        own_emit     = 1'b1;
        own_tok.kind = pcode;
      end else if (cur_byte == slt_pkg::CH_QUOTE) begin
        token_start_next        = off_inc;
        token_start_column_next = current_column;
        mode_next               = slt_pkg::MODE_STR;
      end else if (is_digit || is_word_char) begin
        token_start_next        = byte_offset;
        token_start_column_next = current_column;
        mode_next               = is_digit ? slt_pkg::MODE_NUM : slt_pkg::MODE_ID;
      end else begin
        own_emit        = 1'b1;
        error_seen_next = 1'b1;
      end
    end
  end

  // Pack words: pending token first, the byte's own word after it
  always_comb begin
    res0      = pend_emit ? pend_tok : own_tok;
    res0.last = !(pend_emit && own_emit);
    res1      = own_tok;
    res_cnt   = {1'b0, pend_emit} + {1'b0, own_emit};
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode               <= slt_pkg::MODE_IDLE;
      byte_offset        <= 16'd0;
      token_start        <= 16'd0;
      token_start_column <= 16'd1;
      current_line       <= 16'd1;
      current_column     <= 16'd1;
      error_seen         <= 1'b0;
    end else if (fire) begin
      mode               <= mode_next;
      byte_offset        <= byte_offset_next;
      token_start        <= token_start_next;
      token_start_column <= token_start_column_next;
      current_line       <= current_line_next;
      current_column     <= current_column_next;
      error_seen         <= error_seen_next;
    end
  end

endmodule
`default_nettype wire

### sv/slt_fifo.sv
// Result queue: takes zero, one or two words and pops at most one per cycle.
// Depends on slt_pkg.
`default_nettype none
module slt_fifo (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic [1:0]    push_cnt,
  input  wire slt_pkg::tok_t push0,
  input  wire slt_pkg::tok_t push1,
  output logic               room2,
  output logic               head_valid,
  output slt_pkg::tok_t      head,
  input  wire logic          pop
);

  slt_pkg::tok_t mem [slt_pkg::FIFO_DEPTH];
  logic [slt_pkg::FIFO_AW-1:0] wr_ptr, rd_ptr;
  logic [slt_pkg::FIFO_CW-1:0] count;

  always_comb begin
    room2      = (count <= slt_pkg::FIFO_CW'(slt_pkg::FIFO_DEPTH - 2));
    head_valid = (count != '0);
    head       = mem[rd_ptr];
  end

  // Storage writes
  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) mem[wr_ptr] <= push0;
    if (push_cnt == 2'd2) mem[wr_ptr + slt_pkg::FIFO_AW'(1)] <= push1;
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + slt_pkg::FIFO_AW'(push_cnt);
      rd_ptr <= rd_ptr + slt_pkg::FIFO_AW'(pop);
      count  <= count + slt_pkg::FIFO_CW'(push_cnt) - slt_pkg::FIFO_CW'(pop);
    end
  end

endmodule
`default_nettype wire

### sv/source_lexer_tokenizer_core.sv
// Top level of the source lexer tokenizer: input register, scanner, result queue.
// Depends on slt_pkg, slt_scan and slt_fifo.
//
// Usage: source bytes enter on the input channel (in_valid, in_stall,
// char_byte), one byte per word; byte 0 ends the text. Tokens leave on the
// output channel (out_valid, out_stall and the token fields), one token per
// word. last_of_run marks the final token caused by an input byte.
// A taken byte waits in the input register until the queue has room for two
// words; it is then scanned and its tokens are queued behind any earlier ones.
// Throughput: one byte per cycle while the queue has room for two words.
// A byte that yields two tokens (a number or identifier closed by a punctuator
// or an illegal byte, or any lexeme closed by the terminator) leaves as two
// output words; the four-word result queue absorbs this, and the input register
// holds its byte whenever the queue has less than two free words.
// Reset: rst (synchronous) empties the queue and the input register and
// returns position counters to line 1, column 1, offset 0.
// Receiver stall: head held; a waiting byte stalls with under two words free.
`default_nettype none
module source_lexer_tokenizer_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  char_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [4:0]       token_kind,
  output logic [15:0]      start_offset,
  output logic [15:0]      lexeme_length,
  output logic [15:0]      line_number,
  output logic [15:0]      column_number,
  output logic             had_error,
  output logic             last_of_run
);

  logic          in_full;
  logic [7:0]    in_byte;
  logic          fire, room2;
  logic [1:0]    res_cnt, push_cnt;
  slt_pkg::tok_t res0, res1, head;

  // Input register: the byte waits here until the queue has room
  always_comb begin
    fire     = in_full && room2;
    in_stall = in_full && !room2;
    push_cnt = fire ? res_cnt : 2'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_full <= 1'b1;
    end else if (fire) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) in_byte <= char_byte;
  end

  slt_scan u_scan (
    .clk      (clk),
    .rst      (rst),
    .fire     (fire),
    .cur_byte (in_byte),
    .res0     (res0),
    .res1     (res1),
    .res_cnt  (res_cnt)
  );

  slt_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_cnt   (push_cnt),
    .push0      (res0),
    .push1      (res1),
    .room2      (room2),
    .head_valid (out_valid),
    .head       (head),
    .pop        (out_valid && !out_stall)
  );

  // Output fields
  always_comb begin
    token_kind    = head.kind;
    start_offset  = head.start;
    lexeme_length = head.len;
    line_number   = head.line;
    column_number = head.col;
    had_error     = head.err;
    last_of_run   = head.last;
  end

endmodule
`default_nettype wire

### sv/slt_checker.sv
// Port-level checks for the source lexer tokenizer, bound to the top level.
// Depends on slt_pkg and source_lexer_tokenizer_core.
`default_nettype none
module slt_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [4:0]  token_kind,
  input wire logic [15:0] lexeme_length,
  input wire logic [15:0] line_number,
  input wire logic [15:0] column_number,
  input wire logic        had_error,
  input wire logic        last_of_run
);

  // A held word keeps its kind, length and last flag
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(token_kind) &&
    $stable(lexeme_length) && $stable(last_of_run))
    else $error("output word changed while stalled");

  // The end marker is always the final word of its byte
  a_end_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && token_kind == slt_pkg::KIND_END |-> last_of_run)
    else $error("end marker not last of run");

  // Error flag only rides on the end marker
  a_err_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && had_error |-> token_kind == slt_pkg::KIND_END)
    else $error("error flag on a non-end token");

  // Single-byte tokens have length one
  a_len_one: assert property (@(posedge clk) disable iff (rst)
    out_valid && (token_kind < slt_pkg::KIND_STR || token_kind == slt_pkg::KIND_ILL)
    |-> lexeme_length == 16'd1)
    else $error("punctuator or illegal token with length other than one");

  // Positions count from one
  a_pos: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> line_number != 16'd0 && column_number != 16'd0)
    else $error("line or column is zero");

endmodule

bind source_lexer_tokenizer_core slt_checker u_slt_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .token_kind    (token_kind),
  .lexeme_length (lexeme_length),
  .line_number   (line_number),
  .column_number (column_number),
  .had_error     (had_error),
  .last_of_run   (last_of_run)
);
`default_nettype wire
